// ===== sv/olp_pkg.sv =====
// shared types and constants for the operand literal parser
// phase and radix encodings, result status codes, character class and queue item
// no dependencies
package olp_pkg;

  localparam int ACC_W = 64;

  typedef enum logic [3:0] {
    PH_START,
    PH_ZERO,
    PH_SYM_HEAD,
    PH_SYM_DOT,
    PH_SYM_TAIL,
    PH_NUM_WS,
    PH_NUM_SIGN,
    PH_HEX_ZERO,
    PH_HEX_X,
    PH_DIGITS,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_HEX,
    RX_BIN,
    RX_OCT
  } radix_t;

  localparam logic [1:0] ST_NUMBER = 2'd0;
  localparam logic [1:0] ST_SYMBOL = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       dollar;
    logic       percent;
    logic       zero;
    logic       dec;
    logic       sym_start;
    logic       x_ch;
    logic       b_ch;
    logic       dot;
    logic       word;
    logic       space;
    logic       plus;
    logic       minus;
    logic       dig_ok;
    logic [3:0] digit;
  } chr_class_t;

  typedef struct packed {
    logic       is_end;
    chr_class_t cls;
  } olp_item_t;

endpackage

// ===== sv/olp_front.sv =====
// front stage: takes items from the input channel, classifies the character
// and hands the classified item to the queue; uses olp_pkg
module olp_front import olp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_kind,
  input  logic [7:0] in_ch,
  input  logic      q_full,
  output logic      q_push,
  output olp_item_t q_item
);

  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_B    = 8'h42;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_B    = 8'h62;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_X    = 8'h78;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  logic       fr_valid_r;
  olp_item_t  fr_item_r;
  olp_item_t  item_nxt;
  logic       accept;
  logic       is_upper;
  logic       is_lower;
  logic       is_alpha;
  logic [7:0] sub_dec;
  logic [7:0] sub_lo;
  logic [7:0] sub_up;

  assign in_stall = fr_valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = fr_valid_r && !q_full;
  assign q_item   = fr_item_r;

  assign sub_dec = in_ch - CH_ZERO;
  assign sub_lo  = in_ch - (CH_LO_A - 8'd10);
  assign sub_up  = in_ch - (CH_UP_A - 8'd10);

  always_comb begin
    is_upper = (in_ch >= CH_UP_A) && (in_ch <= CH_UP_Z);
    is_lower = (in_ch >= CH_LO_A) && (in_ch <= CH_LO_Z);
    is_alpha = is_upper || is_lower;

    item_nxt.is_end        = (in_kind == KIND_END);
    item_nxt.cls.dollar    = (in_ch == CH_DOLLAR);
    item_nxt.cls.percent   = (in_ch == CH_PERCENT);
    item_nxt.cls.zero      = (in_ch == CH_ZERO);
    item_nxt.cls.dec       = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
    item_nxt.cls.sym_start = is_alpha || (in_ch == CH_UNDER);
    item_nxt.cls.x_ch      = (in_ch == CH_LO_X) || (in_ch == CH_UP_X);
    item_nxt.cls.b_ch      = (in_ch == CH_LO_B) || (in_ch == CH_UP_B);
    item_nxt.cls.dot       = (in_ch == CH_DOT);
    item_nxt.cls.word      = item_nxt.cls.sym_start || item_nxt.cls.dec;
    item_nxt.cls.space     = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
    item_nxt.cls.plus      = (in_ch == CH_PLUS);
    item_nxt.cls.minus     = (in_ch == CH_MINUS);
    item_nxt.cls.dig_ok    = 1'b1;
    if (item_nxt.cls.dec) begin
      item_nxt.cls.digit = sub_dec[3:0];
    end else if ((in_ch >= CH_LO_A) && (in_ch <= CH_LO_F)) begin
      item_nxt.cls.digit = sub_lo[3:0];
    end else if ((in_ch >= CH_UP_A) && (in_ch <= CH_UP_F)) begin
      item_nxt.cls.digit = sub_up[3:0];
    end else begin
      item_nxt.cls.digit  = 4'd0;
      item_nxt.cls.dig_ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (accept) begin
      fr_valid_r <= 1'b1;
    end else if (q_push) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

// ===== sv/olp_queue.sv =====
// short item queue between the classifying front and the parsing back
// flop storage, one push and one pop per cycle; uses olp_pkg
module olp_queue import olp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  olp_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output olp_item_t head_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  olp_item_t         mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

// ===== sv/olp_back.sv =====
// back stage: runs the operand state machine on classified items, builds the
// 64-bit value with constant-base shift-adds and holds the result register; uses olp_pkg
module olp_back import olp_pkg::*; #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  olp_item_t              q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [VALUE_WIDTH-1:0] out_value
);

  phase_t                 phase_r, phase_nxt;
  radix_t                 radix_r, radix_nxt;
  radix_t                 rx_eff;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic [1:0]             res_status;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [VALUE_WIDTH-1:0] acc_lo;
  logic                   do_take;
  logic                   do_first;
  logic                   digit_lt;
  logic                   digit_ok;
  logic [ACC_W+3:0]       prod;
  logic                   step_ovf;
  logic                   end_pop;
  chr_class_t             cls;

  assign cls     = q_item.cls;
  assign q_pop   = q_valid && (!q_item.is_end || !out_valid_r || !out_stall);
  assign end_pop = q_pop && q_item.is_end;

  // a leading zero switches to octal before the character is read as a digit
  always_comb begin
    if (phase_r == PH_ZERO) begin
      rx_eff = RX_OCT;
    end else if (phase_r == PH_START) begin
      rx_eff = RX_DEC;
    end else begin
      rx_eff = radix_r;
    end
  end

  always_comb begin
    case (rx_eff)
      RX_DEC:  digit_lt = (cls.digit < 4'd10);
      RX_BIN:  digit_lt = (cls.digit < 4'd2);
      RX_OCT:  digit_lt = (cls.digit < 4'd8);
      default: digit_lt = 1'b1;
    endcase
    digit_ok = cls.dig_ok && digit_lt;
  end

  // acc * base + digit in 68 bits; anything above bit 63 is overflow
  always_comb begin
    case (rx_eff)
      RX_HEX:  prod = {acc_r, 4'b0};
      RX_BIN:  prod = {3'b0, acc_r, 1'b0};
      RX_OCT:  prod = {1'b0, acc_r, 3'b0};
      default: prod = {1'b0, acc_r, 3'b0} + {3'b0, acc_r, 1'b0};
    endcase
    prod     = prod + {{ACC_W{1'b0}}, cls.digit};
    step_ovf = |prod[ACC_W+3:ACC_W];
  end

  always_comb begin : next_state
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    do_take   = 1'b0;
    do_first  = 1'b0;
    if (end_pop) begin
      phase_nxt = PH_START;
      radix_nxt = RX_DEC;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      ovf_nxt   = 1'b0;
    end else if (q_pop) begin
      unique case (phase_r) inside
        PH_START: begin
          if (cls.dollar) begin
            radix_nxt = RX_HEX;
            acc_nxt   = '0;
            phase_nxt = PH_NUM_WS;
          end else if (cls.percent) begin
            radix_nxt = RX_BIN;
            acc_nxt   = '0;
            phase_nxt = PH_NUM_WS;
          end else if (cls.zero) begin
            phase_nxt = PH_ZERO;
          end else if (cls.dec) begin
            radix_nxt = RX_DEC;
            do_take   = 1'b1;
            do_first  = 1'b1;
          end else if (cls.sym_start) begin
            phase_nxt = PH_SYM_HEAD;
          end else begin
            phase_nxt = PH_BAD;
          end
        end
        PH_ZERO: begin
          acc_nxt   = '0;
          phase_nxt = PH_NUM_WS;
          if (cls.x_ch) begin
            radix_nxt = RX_HEX;
          end else if (cls.b_ch) begin
            radix_nxt = RX_BIN;
          end else begin
            radix_nxt = RX_OCT;
            if (cls.plus || cls.minus) begin
              neg_nxt   = cls.minus;
              phase_nxt = PH_NUM_SIGN;
            end else if (!cls.space) begin
              do_take  = 1'b1;
              do_first = 1'b1;
            end
          end
        end
        PH_SYM_HEAD: begin
          if (cls.dot) begin
            phase_nxt = PH_SYM_DOT;
          end else if (!cls.word) begin
            phase_nxt = PH_BAD;
          end
        end
        PH_SYM_DOT, PH_SYM_TAIL: begin
          phase_nxt = cls.word ? PH_SYM_TAIL : PH_BAD;
        end
        PH_NUM_WS: begin
          if (cls.plus || cls.minus) begin
            neg_nxt   = cls.minus;
            phase_nxt = PH_NUM_SIGN;
          end else if (radix_r == RX_HEX && cls.zero) begin
            acc_nxt   = '0;
            phase_nxt = PH_HEX_ZERO;
          end else if (!cls.space) begin
            do_take  = 1'b1;
            do_first = 1'b1;
          end
        end
        PH_NUM_SIGN: begin
          if (radix_r == RX_HEX && cls.zero) begin
            acc_nxt   = '0;
            phase_nxt = PH_HEX_ZERO;
          end else begin
            do_take  = 1'b1;
            do_first = 1'b1;
          end
        end
        PH_HEX_ZERO: begin
          if (cls.x_ch) begin
            phase_nxt = PH_HEX_X;
          end else begin
            do_take = 1'b1;
          end
        end
        PH_HEX_X: begin
          do_take  = 1'b1;
          do_first = 1'b1;
        end
        PH_DIGITS: begin
          do_take = 1'b1;
        end
        default: begin
          phase_nxt = PH_BAD;
        end
      endcase
      if (do_take) begin
        if (!digit_ok) begin
          phase_nxt = PH_BAD;
        end else begin
          phase_nxt = PH_DIGITS;
          if (do_first) begin
            acc_nxt = {{(ACC_W-4){1'b0}}, cls.digit};
          end else if (!ovf_r) begin
            if (step_ovf) begin
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = prod[ACC_W-1:0];
            end
          end
        end
      end
    end
  end

  assign acc_lo = acc_r[VALUE_WIDTH-1:0];

  always_comb begin : outputs
    res_status = ST_BAD;
    res_value  = '0;
    unique case (phase_r) inside
      PH_START: begin
        res_status = ST_EMPTY;
      end
      PH_ZERO: begin
        res_status = ST_NUMBER;
      end
      PH_SYM_HEAD, PH_SYM_TAIL: begin
        res_status = ST_SYMBOL;
      end
      PH_HEX_ZERO, PH_DIGITS: begin
        if (!ovf_r) begin
          res_status = ST_NUMBER;
          res_value  = neg_r ? ('0 - acc_lo) : acc_lo;
        end
      end
      default: begin
        res_status = ST_BAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      radix_r     <= RX_DEC;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      if (end_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (end_pop) begin
      out_status_r <= res_status;
      out_value_r  <= res_value;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_pop |=> (phase_r == PH_START) && (acc_r == '0) && !ovf_r && !neg_r)
    else $error("state not cleared after end item");
  a_start_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (radix_r == RX_DEC) && !ovf_r)
    else $error("radix or overflow left over at operand start");
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_NUMBER)) |-> (out_value_r == '0))
    else $error("nonzero value on a non-number result");
`endif

endmodule

// ===== sv/operand_literal_parser.sv =====
// an end item's result passes the front register, the queue and the result register
// before out_valid rises; character items give no result
// throughput: one item per cycle unless a full queue or a held result (out_stall) stalls it
// reset: synchronous active-low rst_n clears the front valid flag, the queue, the parse
// state and the result valid flag; no clearing pass
module operand_literal_parser import olp_pkg::*; #(
  parameter int VALUE_WIDTH = 16,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_kind,
  input  logic [7:0]             in_ch,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_status,
  output logic [VALUE_WIDTH-1:0] out_value
);

  logic      q_full;
  logic      q_push;
  olp_item_t q_push_item;
  logic      q_pop;
  logic      q_not_empty;
  olp_item_t q_head;

  olp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_kind  (in_kind),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  olp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head)
  );

  olp_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_value  (out_value)
  );

endmodule
